>>> rtl/tdt_pkg.sv
package tdt_pkg;

  // field widths
  localparam int MOM_W   = 16;
  localparam int MASS_W  = 16;
  localparam int TIME_W  = 20;
  localparam int LEN_W   = 16;
  localparam int DT_W    = 24;

  // serial unit widths
  localparam int RAD_W   = 50;  // sqrt radicand, padded to an even width
  localparam int ROOT_W  = 25;
  localparam int MA_W    = 33;  // path * tof numerator constant
  localparam int PROD_W  = MA_W + ROOT_W;
  localparam int DIVD_W  = 59;
  localparam int DIVS_W  = 44;
  localparam int QUO_W   = 32;
  localparam int SUM_W   = 35;

  // 1/c scaling: L/c in 1/256 ns = L * C_NUM_VTX / C_DEN
  localparam logic [27:0] C_DEN      = 28'd149896229;
  localparam logic [26:0] C_HALF_DEN = 27'd74948114;
  localparam logic [24:0] C_NUM_VTX  = 25'd20000000;
  localparam logic [16:0] C_NUM_TOF  = 17'd78125;

  localparam logic [15:0] HEAVY_MASS_RST = 16'd3843;
  localparam logic [15:0] LIGHT_MASS_RST = 16'd572;

  localparam logic signed [SUM_W-1:0] DT_MAX = 35'sd8388607;
  localparam logic signed [SUM_W-1:0] DT_MIN = -35'sd8388608;

  localparam logic [1:0] REG_HEAVY_MASS = 2'd0;
  localparam logic [1:0] REG_LIGHT_MASS = 2'd1;

  localparam logic [1:0] CHG_POS = 2'b01;
  localparam logic [1:0] CHG_NEG = 2'b11;

  typedef enum logic [2:0] {
    S_IDLE,
    S_VTX,
    S_PICK,
    S_SQRT,
    S_MUL,
    S_DIV,
    S_FINISH
  } state_t;

endpackage

>>> rtl/tof_delta_t_particle_id.sv
// a hit that opens an event first runs the vertex divide; each valid hypothesis then runs
//   sqrt, multiply and divide in turn; finishing stalls only while the last result waits for out_ready
// one particle at a time: in_ready is high only when idle; a finished result waits in the
//   output register while the next particle is accepted
// rate set by the bit-serial sqrt, shift-add multiply and divide units
// reset: synchronous active-high rst clears control, vertex time to 0, masses to defaults
module tof_delta_t_particle_id
  import tdt_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  // particle input
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    first_in_event,
  input  logic [MOM_W-1:0]        momentum,
  input  logic signed [1:0]       charge,
  input  logic [TIME_W-1:0]       hit_time,
  input  logic [LEN_W-1:0]        path_length,
  // result output
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [DT_W-1:0]  dt_heavy,
  output logic signed [DT_W-1:0]  dt_light,
  output logic                    heavy_valid,
  output logic                    light_valid,
  // configuration writes
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [1:0]              cfg_index,
  input  logic [MASS_W-1:0]       cfg_data
);

  state_t state, state_next;

  // configuration
  logic [MASS_W-1:0] heavy_mass;
  logic [MASS_W-1:0] light_mass;

  // captured particle
  logic [MOM_W-1:0]  p_r;
  logic [TIME_W-1:0] t_r;
  logic [LEN_W-1:0]  len_r;
  logic              hv_r, lv_r;
  logic              pend_h, pend_l;
  logic              cur_light;

  logic signed [DT_W-1:0] vtx_origin;
  logic signed [DT_W-1:0] dth, dtl;

  // serial unit hookup
  logic              sqrt_start, sqrt_done;
  logic              mul_start, mul_done;
  logic              div_start, div_done;
  logic [ROOT_W-1:0] root;
  logic [PROD_W-1:0] prod;
  logic [QUO_W-1:0]  quo;
  logic [DIVD_W-1:0] div_dividend;
  logic [DIVS_W-1:0] div_divisor;

  // derived operands
  logic              in_xfer;
  logic              chg_pos, chg_any;
  logic [MASS_W-1:0] mass_sel;
  logic [32:0]       sq_sum;
  logic [RAD_W-1:0]  radicand;
  logic [MA_W-1:0]   mul_a;
  logic [DIVS_W-1:0] den;
  logic [DIVD_W-1:0] vtx_dividend;
  logic signed [SUM_W-1:0] dt_sum;
  logic signed [DT_W-1:0]  dt_sat;

  assign cfg_ready = 1'b1;
  assign in_xfer   = in_valid && in_ready;
  assign chg_pos   = (charge == CHG_POS);
  assign chg_any   = (charge == CHG_POS) || (charge == CHG_NEG);

  // config registers; an index beyond the list is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      heavy_mass <= HEAVY_MASS_RST;
      light_mass <= LIGHT_MASS_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_HEAVY_MASS) heavy_mass <= cfg_data;
      if (cfg_index == REG_LIGHT_MASS) light_mass <= cfg_data;
    end
  end

  always_comb begin
    // heavy hypothesis runs first when both are pending
    mass_sel     = pend_h ? heavy_mass : light_mass;
    sq_sum       = 33'(32'(p_r) * 32'(p_r)) + 33'(32'(mass_sel) * 32'(mass_sel));
    radicand     = {1'b0, sq_sum, 16'b0};
    mul_a        = MA_W'(MA_W'(len_r) * MA_W'(C_NUM_TOF));
    den          = DIVS_W'(DIVS_W'(p_r) * DIVS_W'(C_DEN));
    vtx_dividend = DIVD_W'(DIVD_W'(path_length) * DIVD_W'(C_NUM_VTX))
                   + DIVD_W'(C_HALF_DEN);
    // delta-t = vertex - t + tof, then clamp to 24 bits
    dt_sum = SUM_W'(vtx_origin) - $signed({15'b0, t_r}) + $signed({3'b0, quo});
    if (dt_sum > DT_MAX)      dt_sat = DT_W'(DT_MAX);
    else if (dt_sum < DT_MIN) dt_sat = DT_W'(DT_MIN);
    else                      dt_sat = DT_W'(dt_sum);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next   = state;
    in_ready     = (state == S_IDLE);
    sqrt_start   = 1'b0;
    mul_start    = 1'b0;
    div_start    = 1'b0;
    div_dividend = {1'b0, prod} + DIVD_W'(den[DIVS_W-1:1]);
    div_divisor  = den;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (first_in_event) begin
            // vertex flight time assumes speed c
            div_start    = 1'b1;
            div_dividend = vtx_dividend;
            div_divisor  = DIVS_W'(C_DEN);
            state_next   = S_VTX;
          end else begin
            state_next = S_PICK;
          end
        end
      end
      S_VTX: begin
        if (div_done) state_next = S_PICK;
      end
      S_PICK: begin
        if (pend_h || pend_l) begin
          sqrt_start = 1'b1;
          state_next = S_SQRT;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_SQRT: begin
        if (sqrt_done) begin
          mul_start  = 1'b1;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        if (mul_done) begin
          // rounding: add half the divisor
          div_start  = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) state_next = S_PICK;
      end
      S_FINISH: begin
        if (!out_valid || out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // particle capture, vertex and per-hypothesis results
  always_ff @(posedge clk) begin
    if (rst) begin
      vtx_origin <= '0;
      pend_h     <= 1'b0;
      pend_l     <= 1'b0;
    end else begin
      if (in_xfer) begin
        pend_h <= (momentum != '0) && chg_pos;
        pend_l <= (momentum != '0) && chg_any;
      end else if (sqrt_start) begin
        if (pend_h) pend_h <= 1'b0;
        else        pend_l <= 1'b0;
      end
      if (state == S_VTX && div_done)
        vtx_origin <= $signed({4'b0, t_r}) - $signed(quo[DT_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      p_r   <= momentum;
      t_r   <= hit_time;
      len_r <= path_length;
      hv_r  <= (momentum != '0) && chg_pos;
      lv_r  <= (momentum != '0) && chg_any;
      dth   <= '0;
      dtl   <= '0;
    end else begin
      if (sqrt_start) cur_light <= !pend_h;
      if (state == S_DIV && div_done) begin
        if (cur_light) dtl <= dt_sat;
        else           dth <= dt_sat;
      end
    end
  end

  // output register: new result loads once the previous one is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_FINISH && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FINISH && (!out_valid || out_ready)) begin
      dt_heavy    <= dth;
      dt_light    <= dtl;
      heavy_valid <= hv_r;
      light_valid <= lv_r;
    end
  end

  tdt_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (radicand),
    .root     (root),
    .done     (sqrt_done)
  );

  tdt_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (root),
    .prod  (prod),
    .done  (mul_done)
  );

  tdt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (quo),
    .done     (div_done)
  );

`ifndef NO_ASSERTIONS
  a_heavy_implies_light: assert property (@(posedge clk) disable iff (rst)
    out_valid && heavy_valid |-> light_valid)
    else $error("heavy result without light result");

  a_heavy_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !heavy_valid |-> dt_heavy == '0)
    else $error("dt_heavy nonzero for invalid hypothesis");

  a_light_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !light_valid |-> dt_light == '0)
    else $error("dt_light nonzero for invalid hypothesis");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state != S_IDLE)
    else $error("input transfer did not start work");

  a_one_unit: assert property (@(posedge clk) disable iff (rst)
    $onehot0({sqrt_start, mul_start, div_start}))
    else $error("two serial units started together");
`endif

endmodule

>>> rtl/tdt_isqrt.sv
module tdt_isqrt
  import tdt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [RAD_W-1:0]  radicand,
  output logic [ROOT_W-1:0] root,
  output logic              done
);

  logic [RAD_W-1:0]  rad;
  logic [ROOT_W+1:0] rem;
  logic [4:0]        cnt;
  logic              busy;

  logic [ROOT_W+3:0] r4;
  logic [ROOT_W+3:0] trial;
  logic              take;

  // two radicand bits per cycle
  always_comb begin
    r4    = {rem, rad[RAD_W-1 -: 2]};
    trial = {2'b00, root, 2'b01};
    take  = (r4 >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'(ROOT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad  <= {rad[RAD_W-3:0], 2'b00};
      root <= {root[ROOT_W-2:0], take};
      if (take) rem <= (ROOT_W+2)'(r4 - trial);
      else      rem <= (ROOT_W+2)'(r4);
    end
  end

endmodule

>>> rtl/tdt_mul.sv
module tdt_mul
  import tdt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [MA_W-1:0]   a,
  input  logic [ROOT_W-1:0] b,
  output logic [PROD_W-1:0] prod,
  output logic              done
);

  logic [MA_W-1:0] a_r;
  logic [4:0]      cnt;
  logic            busy;
  logic [MA_W:0]   sum;

  // shift-add, one multiplier bit per cycle, lsb first
  always_comb begin
    sum = {1'b0, prod[PROD_W-1:ROOT_W]};
    if (prod[0]) sum = sum + {1'b0, a_r};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'(ROOT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r  <= a;
      prod <= {{MA_W{1'b0}}, b};
    end else if (busy) begin
      prod <= {sum, prod[ROOT_W-1:1]};
    end
  end

endmodule

>>> rtl/tdt_div.sv
module tdt_div
  import tdt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIVD_W-1:0] dividend,
  input  logic [DIVS_W-1:0] divisor,
  output logic [QUO_W-1:0]  quotient,
  output logic              done
);

  logic [DIVS_W-1:0] dvs;
  logic [DIVS_W-1:0] rem;
  logic [4:0]        cnt;
  logic              busy;
  logic [DIVS_W:0]   r2;
  logic              take;

  // quotient fits 32 bits, so the upper dividend bits start as the remainder
  always_comb begin
    r2   = {rem, quotient[QUO_W-1]};
    take = (r2 >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'(QUO_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // quotient register doubles as the dividend shift line
  always_ff @(posedge clk) begin
    if (start) begin
      dvs      <= divisor;
      rem      <= DIVS_W'(dividend[DIVD_W-1:QUO_W]);
      quotient <= dividend[QUO_W-1:0];
    end else if (busy) begin
      quotient <= {quotient[QUO_W-2:0], take};
      if (take) rem <= DIVS_W'(r2 - {1'b0, dvs});
      else      rem <= DIVS_W'(r2);
    end
  end

endmodule
